@@ rtl/mesh_vertex_neighbour_smoothing_core_defines.svh @@
// ---------------------------------------------------------------------------
// mesh vertex smoothing core assertion macros
// shared property wrappers clocked on clk and disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef MESH_VERTEX_NEIGHBOUR_SMOOTHING_CORE_DEFINES_SVH
`define MESH_VERTEX_NEIGHBOUR_SMOOTHING_CORE_DEFINES_SVH

// same-cycle implication
`define MVNS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MVNS_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mvns_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvns_pkg
// widths, codes, control bundle and reciprocal table of the smoothing core
// ---------------------------------------------------------------------------
package mvns_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = VIDX_W + 1;
	localparam int HEIGHT_W     = 16;
	localparam int NB_MAX       = 6;
	localparam int NBC_W        = 3;
	localparam int NBSEL_W      = $clog2(NB_MAX);
	// neighbour sum needs three extra bits for six terms
	localparam int ACC_W        = HEIGHT_W + 3;
	localparam int MAG_W        = ACC_W - 1;
	// reciprocal scale: error stays below one half for any magnitude
	localparam int RECIP_SHIFT  = MAG_W + 1;
	localparam int RECIP_W      = RECIP_SHIFT + 1;
	localparam int PROD_W       = MAG_W + RECIP_W;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_SMOOTH = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_VERTEX = 2'd1,
		STAT_BAD_NB    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_READ_WAIT,
		S_ROW,
		S_GATHER,
		S_DRAIN,
		S_MUL,
		S_FIX,
		S_FIN,
		S_WRITE
	} state_t;

	// one stored neighbour row
	typedef struct packed {
		logic [NBC_W-1:0]              cnt;
		logic [NB_MAX-1:0][VIDX_W-1:0] nb;
	} nb_row_t;

	// sequencer to arithmetic unit
	typedef struct packed {
		logic clear_en;
		logic own_en;
		logic acc_en;
		logic mul_en;
		logic fix_en;
		logic fin_en;
	} dp_ctl_t;

	// floor(2^RECIP_SHIFT / c), zero for counts that mean nothing
	function automatic logic [RECIP_W-1:0] recip(input logic [NBC_W-1:0] c);
		logic [RECIP_W-1:0] r;
		unique case (c)
			3'd1:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 1);
			3'd2:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 2);
			3'd3:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 3);
			3'd4:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 4);
			3'd5:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 5);
			3'd6:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 6);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/mvns_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvns_ram
// simple dual port memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module mvns_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/mvns_dpath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvns_dpath
// shared arithmetic unit: neighbour accumulate, mean by reciprocal, halving
// ---------------------------------------------------------------------------
module mvns_dpath import mvns_pkg::*; (
	input  logic                       clk,
	input  dp_ctl_t                    ctl,
	input  logic signed [HEIGHT_W-1:0] rd_height,
	input  logic [NBC_W-1:0]           nb_cnt,
	output logic signed [HEIGHT_W-1:0] new_height
);

	logic signed [ACC_W-1:0]    acc_q;
	logic signed [HEIGHT_W-1:0] own_q;
	logic [MAG_W-1:0]           mag_s1;
	logic                       neg_s1;
	logic [PROD_W-1:0]          prod_s1;
	logic [MAG_W-1:0]           quot_s2;
	logic                       neg_s2;
	logic signed [HEIGHT_W-1:0] result_q;

	logic signed [ACC_W-1:0]    acc_abs;
	logic [MAG_W-1:0]           quot_est;
	logic [MAG_W+NBC_W-1:0]     quot_x_cnt;
	logic [MAG_W+NBC_W-1:0]     remainder;
	logic signed [ACC_W-1:0]    mean;
	logic signed [ACC_W-1:0]    total;

	// accumulate neighbour heights, capture own height
	always_ff @(posedge clk) begin
		if (ctl.clear_en) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + ACC_W'(rd_height);
		end
		if (ctl.own_en) begin
			own_q <= rd_height;
		end
	end

	// magnitude times reciprocal of the count
	assign acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			mag_s1  <= acc_abs[MAG_W-1:0];
			neg_s1  <= acc_q[ACC_W-1];
			prod_s1 <= PROD_W'(acc_abs[MAG_W-1:0]) * PROD_W'(recip(nb_cnt));
		end
	end

	// estimate is exact or one short; one compare corrects it
	assign quot_est   = prod_s1[RECIP_SHIFT+MAG_W-1:RECIP_SHIFT];
	assign quot_x_cnt = (MAG_W+NBC_W)'(quot_est) * (MAG_W+NBC_W)'(nb_cnt);
	assign remainder  = (MAG_W+NBC_W)'(mag_s1) - quot_x_cnt;

	always_ff @(posedge clk) begin
		if (ctl.fix_en) begin
			neg_s2 <= neg_s1;
			if (nb_cnt == '0) begin
				quot_s2 <= '0;
			end else if (remainder >= (MAG_W+NBC_W)'(nb_cnt)) begin
				quot_s2 <= quot_est + 1'b1;
			end else begin
				quot_s2 <= quot_est;
			end
		end
	end

	// own plus signed mean, then arithmetic halving
	assign mean  = neg_s2 ? -signed'({1'b0, quot_s2}) : signed'({1'b0, quot_s2});
	assign total = ACC_W'(own_q) + mean;

	always_ff @(posedge clk) begin
		if (ctl.fin_en) begin
			result_q <= total[HEIGHT_W:1];
		end
	end

	assign new_height = result_q;

endmodule

@@ rtl/mesh_vertex_neighbour_smoothing_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mesh_vertex_neighbour_smoothing_core
// per-vertex height and neighbour store with in-place laplacian sweep
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low; every command gives
// exactly one result, shown on height_out and status for a single cycle while
// done is high. The receiver cannot stall: the result must be taken in that
// cycle. A smoothing sweep is paced by the one read port of the height memory
// (own and neighbour heights fetched one per cycle) and the shared multiply
// path for the mean. A new command may be issued in the cycle that done is
// high. vertex_count is written through cfg_valid/cfg_ready while the core is
// idle.
module mesh_vertex_neighbour_smoothing_core import mvns_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic [VIDX_W-1:0]          vertex_index,
	input  logic signed [HEIGHT_W-1:0] height_in,
	input  logic [NBC_W-1:0]           neighbour_count,
	input  logic [VIDX_W-1:0]          neighbour_a,
	input  logic [VIDX_W-1:0]          neighbour_b,
	input  logic [VIDX_W-1:0]          neighbour_c,
	input  logic [VIDX_W-1:0]          neighbour_d,
	input  logic [VIDX_W-1:0]          neighbour_e,
	input  logic [VIDX_W-1:0]          neighbour_f,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [VCNT_W-1:0]          cfg_data,
	output logic                       done,
	output logic signed [HEIGHT_W-1:0] height_out,
	output logic [1:0]                 status
);

`include "mesh_vertex_neighbour_smoothing_core_defines.svh"

	state_t                        state_q, state_d;
	logic [VCNT_W-1:0]             vc_q;
	logic [VCNT_W-1:0]             i_q, i_d, i_next;
	logic [NBC_W-1:0]              j_q, j_d;
	logic                          pown_q, pown_d;
	logic                          pnb_q, pnb_d;

	op_t                           op_q;
	logic [VIDX_W-1:0]             idx_q;
	logic signed [HEIGHT_W-1:0]    hin_q;
	logic [NBC_W-1:0]              ncnt_q;
	logic [NB_MAX-1:0][VIDX_W-1:0] nb_q;

	logic                          done_q;
	logic signed [HEIGHT_W-1:0]    height_out_q;
	status_t                       status_q;

	logic                          idx_ok;
	logic                          nb_bad;
	nb_row_t                       row_wdata, row_rdata;
	logic                          row_we, row_re;
	logic [NBC_W-1:0]              cnt_eff;
	logic [NBSEL_W-1:0]            nb_sel;

	logic                          ht_we, ht_re;
	logic [VIDX_W-1:0]             ht_waddr, ht_raddr;
	logic signed [HEIGHT_W-1:0]    ht_wdata, ht_rdata;
	logic signed [HEIGHT_W-1:0]    new_height;
	dp_ctl_t                       ctl;

	logic                          resp_valid;
	status_t                       resp_status;
	logic signed [HEIGHT_W-1:0]    resp_height;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VCNT_W'(MAX_VERTICES);
		end else if (cfg_valid && cfg_ready) begin
			vc_q <= cfg_data;
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q   <= op_t'(operation);
			idx_q  <= vertex_index;
			hin_q  <= height_in;
			ncnt_q <= neighbour_count;
			nb_q   <= {neighbour_f, neighbour_e, neighbour_d,
			           neighbour_c, neighbour_b, neighbour_a};
		end
	end

	// load and read checks against the current vertex count
	assign idx_ok = ({1'b0, idx_q} < vc_q);

	always_comb begin
		nb_bad = (ncnt_q == '0) || (ncnt_q > NBC_W'(NB_MAX));
		for (int k = 0; k < NB_MAX; k++) begin
			if ((NBC_W'(k) < ncnt_q) && ({1'b0, nb_q[k]} >= vc_q)) begin
				nb_bad = 1'b1;
			end
		end
	end

	// neighbour row written by load, unused slots zeroed
	always_comb begin
		row_wdata.cnt = ncnt_q;
		for (int k = 0; k < NB_MAX; k++) begin
			row_wdata.nb[k] = (NBC_W'(k) < ncnt_q) ? nb_q[k] : '0;
		end
	end

	assign cnt_eff = (row_rdata.cnt > NBC_W'(NB_MAX)) ? NBC_W'(NB_MAX) : row_rdata.cnt;
	assign nb_sel  = NBSEL_W'(j_q - 1'b1);
	assign i_next  = i_q + 1'b1;

	mvns_ram #(
		.ADDR_W (VIDX_W),
		.DATA_W ($bits(nb_row_t))
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (idx_q),
		.wdata (row_wdata),
		.re    (row_re),
		.raddr (i_q[VIDX_W-1:0]),
		.rdata (row_rdata)
	);

	mvns_ram #(
		.ADDR_W (VIDX_W),
		.DATA_W (HEIGHT_W)
	) u_height_ram (
		.clk   (clk),
		.we    (ht_we),
		.waddr (ht_waddr),
		.wdata (ht_wdata),
		.re    (ht_re),
		.raddr (ht_raddr),
		.rdata (ht_rdata)
	);

	mvns_dpath u_dpath (
		.clk        (clk),
		.ctl        (ctl),
		.rd_height  (ht_rdata),
		.nb_cnt     (cnt_eff),
		.new_height (new_height)
	);

	// sequencer state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			pown_q  <= 1'b0;
			pnb_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			pown_q  <= pown_d;
			pnb_q   <= pnb_d;
		end
	end

	// next state and control
	always_comb begin
		state_d     = state_q;
		i_d         = i_q;
		j_d         = j_q;
		pown_d      = 1'b0;
		pnb_d       = 1'b0;
		ht_we       = 1'b0;
		ht_waddr    = idx_q;
		ht_wdata    = hin_q;
		ht_re       = 1'b0;
		ht_raddr    = idx_q;
		row_we      = 1'b0;
		row_re      = 1'b0;
		ctl         = '0;
		resp_valid  = 1'b0;
		resp_status = STAT_OK;
		resp_height = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_IDLE;
				unique case (op_q)
					OP_LOAD: begin
						resp_valid = 1'b1;
						if (!idx_ok) begin
							resp_status = STAT_BAD_VERTEX;
						end else if (nb_bad) begin
							resp_status = STAT_BAD_NB;
						end else begin
							ht_we  = 1'b1;
							row_we = 1'b1;
						end
					end
					OP_SMOOTH: begin
						i_d = '0;
						if (vc_q == '0) begin
							resp_valid = 1'b1;
						end else begin
							state_d = S_ROW;
						end
					end
					OP_READ: begin
						if (!idx_ok) begin
							resp_valid  = 1'b1;
							resp_status = STAT_BAD_VERTEX;
						end else begin
							ht_re   = 1'b1;
							state_d = S_READ_WAIT;
						end
					end
					default: begin
						resp_valid = 1'b1;
					end
				endcase
			end
			S_READ_WAIT: begin
				resp_valid  = 1'b1;
				resp_height = ht_rdata;
				state_d     = S_IDLE;
			end
			S_ROW: begin
				row_re       = 1'b1;
				ctl.clear_en = 1'b1;
				j_d          = '0;
				state_d      = S_GATHER;
			end
			S_GATHER: begin
				// own height first, then one neighbour per cycle
				ctl.own_en = pown_q;
				ctl.acc_en = pnb_q;
				ht_re      = 1'b1;
				ht_raddr   = (j_q == '0) ? i_q[VIDX_W-1:0] : row_rdata.nb[nb_sel];
				pown_d     = (j_q == '0);
				pnb_d      = (j_q != '0);
				j_d        = j_q + 1'b1;
				if (j_q >= cnt_eff) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				ctl.own_en = pown_q;
				ctl.acc_en = pnb_q;
				state_d    = S_MUL;
			end
			S_MUL: begin
				ctl.mul_en = 1'b1;
				state_d    = S_FIX;
			end
			S_FIX: begin
				ctl.fix_en = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				ctl.fin_en = 1'b1;
				state_d    = S_WRITE;
			end
			S_WRITE: begin
				ht_we    = 1'b1;
				ht_waddr = i_q[VIDX_W-1:0];
				ht_wdata = new_height;
				i_d      = i_next;
				if ((i_next >= vc_q) || i_next[VCNT_W-1]) begin
					resp_valid = 1'b1;
					state_d    = S_IDLE;
				end else begin
					state_d = S_ROW;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// result transaction, one cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= resp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_valid) begin
			height_out_q <= resp_height;
			status_q     <= resp_status;
		end
	end

	assign done       = done_q;
	assign height_out = height_out_q;
	assign status     = status_q;

	// checks
	`MVNS_ASSERT_IMP(a_done_when_idle, done, !busy, "result strobe while busy")
	`MVNS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command left core idle")
	`MVNS_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`MVNS_ASSERT_IMP(a_sweep_in_range, state_q == S_GATHER,
		!i_q[VCNT_W-1] && (i_q < vc_q), "sweep vertex beyond count")

endmodule
